### hdl/nbs_pkg.sv
// ============================================================================
// nbs_pkg - shared definitions for the navigation bit synchronizer
// Field widths, register reset values, register indexes, sign codes and the
// result record passed from the controller to the output stage.
// ============================================================================
package nbs_pkg;

   localparam int PROMPT_W     = 24;
   localparam int SAMPLE_W     = 64;
   localparam int PHASE_OUT_W  = 5;
   localparam int PULL_W       = 8;
   localparam int WIN_W        = 11;
   localparam int HIST_W       = 11;
   localparam int CSR_DATA_W   = 11;
   localparam int CSR_IDX_W    = 1;
   localparam int REQ_DATA_W   = 88;
   localparam int RSP_FIELDS_W = 70;
   localparam int RSP_DATA_W   = 72;

   localparam int MS_PER_BIT_DEF = 20;

   localparam logic [PULL_W-1:0] PULL_IN_RESET     = 8'd100;
   localparam logic [WIN_W-1:0]  SYNC_WINDOW_RESET = 11'd1500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULL_IN     = 1'b0,
      CSR_SYNC_WINDOW = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SGN_ZERO = 2'd0, SGN_POS = 2'd1, SGN_NEG = 2'd2
   } sign_type;

   typedef struct packed {
      logic                   nav_bit;
      logic [SAMPLE_W-1:0]    bit_start_sample;
      logic [PHASE_OUT_W-1:0] boundary_phase;
   } rsp_item_type;

endpackage

### hdl/nbs_hist_mem.sv
// ============================================================================
// nbs_hist_mem - transition histogram storage
// One-port-read, one-port-write synchronous RAM with registered read data.
// Per-bin valid flags make every bin read as zero until first written.
// ============================================================================
module nbs_hist_mem #(
   parameter int DEPTH = nbs_pkg::MS_PER_BIT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [nbs_pkg::HIST_W-1:0]    rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [nbs_pkg::HIST_W-1:0]    wr_data
);

   logic [nbs_pkg::HIST_W-1:0] ram_ff [DEPTH];
   logic [DEPTH-1:0]           valid_ff;
   logic [nbs_pkg::HIST_W-1:0] rdata_ff;
   logic                       rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= ram_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // unwritten bins read as zero
   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

### hdl/nbs_ctrl.sv
// ============================================================================
// nbs_ctrl - bit synchronizer sequencer
// Pull-in, histogram read-modify-write, argmax scan over the bin memory,
// boundary wait and per-bit integration.
// ============================================================================
module nbs_ctrl #(
   parameter int MS_PER_BIT = nbs_pkg::MS_PER_BIT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic signed [nbs_pkg::PROMPT_W-1:0]   prompt_value,
   input  logic [nbs_pkg::SAMPLE_W-1:0]          sample_index,
   input  logic [nbs_pkg::PULL_W-1:0]            pull_in_ms,
   input  logic [nbs_pkg::WIN_W-1:0]             sync_window_ms,
   input  logic                                  slot_free,
   output logic                                  emit_valid,
   output nbs_pkg::rsp_item_type                 emit_item,
   output logic                                  hist_rd_en,
   output logic [$clog2(MS_PER_BIT)-1:0]         hist_rd_addr,
   input  logic [nbs_pkg::HIST_W-1:0]            hist_rd_data,
   output logic                                  hist_wr_en,
   output logic [$clog2(MS_PER_BIT)-1:0]         hist_wr_addr,
   output logic [nbs_pkg::HIST_W-1:0]            hist_wr_data
);

   localparam int PH_W  = $clog2(MS_PER_BIT);
   localparam int CNT_W = $clog2(MS_PER_BIT + 1);
   localparam int EN_W  = nbs_pkg::PROMPT_W + $clog2(MS_PER_BIT);
   localparam int POW   = nbs_pkg::PHASE_OUT_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_HIST, ST_SCAN, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SP_PULL_IN, SP_HIST, SP_WAIT, SP_INTEG
   } sync_type;

   state_type                            state_ff, state_in;
   sync_type                             sync_ff, sync_in;
   logic [nbs_pkg::PULL_W-1:0]           pull_cnt_ff, pull_cnt_in;
   logic [nbs_pkg::WIN_W-1:0]            win_cnt_ff, win_cnt_in;
   logic [PH_W-1:0]                      ms_phase_ff, ms_phase_in;
   nbs_pkg::sign_type                    last_sign_ff, last_sign_in;
   logic [PH_W-1:0]                      boundary_ff, boundary_in;
   logic [CNT_W-1:0]                     ms_in_bit_ff, ms_in_bit_in;
   logic signed [EN_W-1:0]               energy_ff, energy_in;
   logic [nbs_pkg::SAMPLE_W-1:0]         bit_start_ff, bit_start_in;
   logic signed [nbs_pkg::PROMPT_W-1:0]  value_ff, value_in;
   logic [nbs_pkg::SAMPLE_W-1:0]         sidx_ff, sidx_in;
   logic [CNT_W-1:0]                     scan_cnt_ff, scan_cnt_in;
   logic                                 rd_pend_ff, rd_pend_in;
   logic [PH_W-1:0]                      rd_idx_ff, rd_idx_in;
   logic [nbs_pkg::HIST_W-1:0]           best_val_ff, best_val_in;
   logic [PH_W-1:0]                      best_idx_ff, best_idx_in;

   logic [PH_W-1:0]                      phase_next;
   logic [nbs_pkg::PULL_W-1:0]           pull_sat;
   logic [nbs_pkg::WIN_W-1:0]            win_sat;
   logic [CNT_W-1:0]                     mib_next;
   nbs_pkg::sign_type                    sgn;
   logic                                 reversal;
   logic                                 take;

   assign phase_next = (ms_phase_ff == PH_W'(MS_PER_BIT - 1)) ? '0 : ms_phase_ff + 1'b1;
   assign pull_sat   = (pull_cnt_ff != '1) ? pull_cnt_ff + 1'b1 : pull_cnt_ff;
   assign win_sat    = (win_cnt_ff != '1) ? win_cnt_ff + 1'b1 : win_cnt_ff;
   assign mib_next   = ms_in_bit_ff + 1'b1;

   always_comb begin
      if (value_ff == '0) begin
         sgn = nbs_pkg::SGN_ZERO;
      end else if (value_ff[nbs_pkg::PROMPT_W-1]) begin
         sgn = nbs_pkg::SGN_NEG;
      end else begin
         sgn = nbs_pkg::SGN_POS;
      end
   end

   assign reversal = ((sgn == nbs_pkg::SGN_POS) && (last_sign_ff == nbs_pkg::SGN_NEG)) ||
                     ((sgn == nbs_pkg::SGN_NEG) && (last_sign_ff == nbs_pkg::SGN_POS));

   // first maximum wins: only a strictly larger bin replaces the best
   assign take = (rd_idx_ff == '0) || (hist_rd_data > best_val_ff);

   assign req_tready = (state_ff == ST_IDLE);

   assign emit_item.nav_bit          = ~energy_ff[EN_W-1];
   assign emit_item.bit_start_sample = bit_start_ff;
   assign emit_item.boundary_phase   = POW'(boundary_ff);

   always_comb begin
      state_in     = state_ff;
      sync_in      = sync_ff;
      pull_cnt_in  = pull_cnt_ff;
      win_cnt_in   = win_cnt_ff;
      ms_phase_in  = ms_phase_ff;
      last_sign_in = last_sign_ff;
      boundary_in  = boundary_ff;
      ms_in_bit_in = ms_in_bit_ff;
      energy_in    = energy_ff;
      bit_start_in = bit_start_ff;
      value_in     = value_ff;
      sidx_in      = sidx_ff;
      scan_cnt_in  = scan_cnt_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      best_val_in  = best_val_ff;
      best_idx_in  = best_idx_ff;
      hist_rd_en   = 1'b0;
      hist_rd_addr = ms_phase_ff;
      hist_wr_en   = 1'b0;
      hist_wr_addr = ms_phase_ff;
      hist_wr_data = hist_rd_data + 1'b1;
      emit_valid   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               value_in = prompt_value;
               sidx_in  = sample_index;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (sync_ff)
               SP_PULL_IN: begin
                  pull_cnt_in = pull_sat;
                  if (pull_sat < pull_in_ms) begin
                     state_in = ST_IDLE;
                  end else begin
                     // this request already feeds the histogram
                     sync_in    = SP_HIST;
                     hist_rd_en = 1'b1;
                     state_in   = ST_HIST;
                  end
               end
               SP_HIST: begin
                  hist_rd_en = 1'b1;
                  state_in   = ST_HIST;
               end
               SP_WAIT: begin
                  if (ms_phase_ff == boundary_ff) begin
                     sync_in      = SP_INTEG;
                     ms_in_bit_in = CNT_W'(1);
                     energy_in    = EN_W'(value_ff);
                     bit_start_in = sidx_ff;
                  end
                  ms_phase_in = phase_next;
                  state_in    = ST_IDLE;
               end
               SP_INTEG: begin
                  if (ms_in_bit_ff == '0) begin
                     bit_start_in = sidx_ff;
                  end
                  energy_in    = energy_ff + EN_W'(value_ff);
                  ms_in_bit_in = mib_next;
                  ms_phase_in  = phase_next;
                  state_in     = (mib_next == CNT_W'(MS_PER_BIT)) ? ST_EMIT : ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_HIST: begin
            // bin value for ms_phase_ff is on the read port now
            hist_wr_en   = reversal && (hist_rd_data != '1);
            last_sign_in = sgn;
            ms_phase_in  = phase_next;
            win_cnt_in   = win_sat;
            if (win_sat >= sync_window_ms) begin
               scan_cnt_in = '0;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            if (scan_cnt_ff < CNT_W'(MS_PER_BIT)) begin
               hist_rd_en   = 1'b1;
               hist_rd_addr = scan_cnt_ff[PH_W-1:0];
               scan_cnt_in  = scan_cnt_ff + 1'b1;
               rd_pend_in   = 1'b1;
               rd_idx_in    = scan_cnt_ff[PH_W-1:0];
            end
            if (rd_pend_ff) begin
               if (take) begin
                  best_val_in = hist_rd_data;
                  best_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == PH_W'(MS_PER_BIT - 1)) begin
                  boundary_in = take ? rd_idx_ff : best_idx_ff;
                  sync_in     = SP_WAIT;
                  state_in    = ST_IDLE;
               end
            end
         end

         ST_EMIT: begin
            if (slot_free) begin
               emit_valid   = 1'b1;
               energy_in    = '0;
               ms_in_bit_in = '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sync_ff      <= SP_PULL_IN;
         pull_cnt_ff  <= '0;
         win_cnt_ff   <= '0;
         ms_phase_ff  <= '0;
         last_sign_ff <= nbs_pkg::SGN_ZERO;
         boundary_ff  <= '0;
         ms_in_bit_ff <= '0;
         energy_ff    <= '0;
         bit_start_ff <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sync_ff      <= sync_in;
         pull_cnt_ff  <= pull_cnt_in;
         win_cnt_ff   <= win_cnt_in;
         ms_phase_ff  <= ms_phase_in;
         last_sign_ff <= last_sign_in;
         boundary_ff  <= boundary_in;
         ms_in_bit_ff <= ms_in_bit_in;
         energy_ff    <= energy_in;
         bit_start_ff <= bit_start_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      sidx_ff     <= sidx_in;
      scan_cnt_ff <= scan_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
   end

endmodule

### hdl/nav_bit_sync_integrator_top.sv
// ============================================================================
// nav_bit_sync_integrator_top - navigation bit synchronizer and integrator
// Finds the bit boundary from a sign reversal histogram of 1 ms prompt values,
// then emits one sign decision per MS_PER_BIT milliseconds.
// ============================================================================
// Each request carries one 1 ms prompt value and the sample index where that
// millisecond starts. After the pull-in period, reversals of sign between
// consecutive values are counted into MS_PER_BIT phase bins held in a small
// synchronous RAM; when the sync window closes the bins are scanned and the
// first largest bin becomes the boundary phase. From then on MS_PER_BIT values
// are summed per bit and each finished bit is sent as one response. A request
// is finished before the next one is taken. While the histogram is built a
// request reads, modifies and writes one bin; the request that closes the
// window also runs the argmax scan, one bin read per cycle. A request that
// completes a bit waits while the previous response is still held in the
// output register. The bins clear at reset through per-bin valid flags, so no
// clearing pass is needed. CSR writes land at once; write them only while no
// request is in flight.
module nav_bit_sync_integrator_top #(
   parameter int MS_PER_BIT = nbs_pkg::MS_PER_BIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: [23:0] prompt_value, [87:24] sample_index
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [nbs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // response: [0] nav_bit, [64:1] bit_start_sample, [69:65] boundary_phase,
   // [71:70] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [nbs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // CSR write port: index 0 pull_in_ms, index 1 sync_window_ms
   input  logic                               csr_we,
   input  logic [nbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PH_W = $clog2(MS_PER_BIT);

   logic [nbs_pkg::PULL_W-1:0]          pull_in_ff, pull_in_in;
   logic [nbs_pkg::WIN_W-1:0]           sync_win_ff, sync_win_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   nbs_pkg::rsp_item_type               rsp_item_ff, rsp_item_in;

   logic signed [nbs_pkg::PROMPT_W-1:0] prompt_value;
   logic [nbs_pkg::SAMPLE_W-1:0]        sample_index;
   logic                                slot_free;
   logic                                emit_valid;
   nbs_pkg::rsp_item_type               emit_item;

   logic                                hist_rd_en;
   logic [PH_W-1:0]                     hist_rd_addr;
   logic [nbs_pkg::HIST_W-1:0]          hist_rd_data;
   logic                                hist_wr_en;
   logic [PH_W-1:0]                     hist_wr_addr;
   logic [nbs_pkg::HIST_W-1:0]          hist_wr_data;

   assign prompt_value = req_tdata[nbs_pkg::PROMPT_W-1:0];
   assign sample_index = req_tdata[nbs_pkg::REQ_DATA_W-1:nbs_pkg::PROMPT_W];

   // output register frees up in the same cycle it is taken
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      pull_in_in  = pull_in_ff;
      sync_win_in = sync_win_ff;
      if (csr_we) begin
         case (csr_index)
            nbs_pkg::CSR_PULL_IN:     pull_in_in  = csr_wdata[nbs_pkg::PULL_W-1:0];
            nbs_pkg::CSR_SYNC_WINDOW: sync_win_in = csr_wdata[nbs_pkg::WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit_valid) begin
         rsp_item_in  = emit_item;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pull_in_ff   <= nbs_pkg::PULL_IN_RESET;
         sync_win_ff  <= nbs_pkg::SYNC_WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pull_in_ff   <= pull_in_in;
         sync_win_ff  <= sync_win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff.boundary_phase,
                        rsp_item_ff.bit_start_sample, rsp_item_ff.nav_bit};

   nbs_ctrl #(
      .MS_PER_BIT (MS_PER_BIT)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .prompt_value   (prompt_value),
      .sample_index   (sample_index),
      .pull_in_ms     (pull_in_ff),
      .sync_window_ms (sync_win_ff),
      .slot_free      (slot_free),
      .emit_valid     (emit_valid),
      .emit_item      (emit_item),
      .hist_rd_en     (hist_rd_en),
      .hist_rd_addr   (hist_rd_addr),
      .hist_rd_data   (hist_rd_data),
      .hist_wr_en     (hist_wr_en),
      .hist_wr_addr   (hist_wr_addr),
      .hist_wr_data   (hist_wr_data)
   );

   nbs_hist_mem #(
      .DEPTH (MS_PER_BIT)
   ) u_hist_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data)
   );

   // a new bit never overwrites a response that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> slot_free)
      else $error("response overwritten before taken");

   // the sequencer never emits while it is open for a new request
   a_emit_not_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !emit_valid)
      else $error("emit while accepting requests");

   // reported boundary stays inside the bit period
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_item_ff.boundary_phase} <
                        (nbs_pkg::PHASE_OUT_W + 1)'(MS_PER_BIT)))
      else $error("boundary phase out of range");

endmodule

### verif/testbench.sv
// ============================================================================
// testbench - navigation bit synchronizer and integrator
// Streams 1 ms prompt values with sample indexes through the pull-in, the
// reversal histogram and the bit integration, predicts every bit decision
// and checks each response field by field against the prediction.
// ============================================================================
module testbench;

   import nbs_pkg::*;

   localparam int BIT_MS         = MS_PER_BIT_DEF;
   // long enough for a boundary scan to finish before a CSR write
   localparam int SETTLE_CYCLES  = 2 * BIT_MS + 8;
   localparam int HOLD_CYCLES    = 1500;   // long receiver hold-off
   // idle cycles with no handshake at all; the hold-off is the longest legal one
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 1700;
   localparam int HIST_ITEMS     = 60;

   localparam logic signed [PROMPT_W-1:0] PROMPT_MAX = 24'sh7FFFFF;
   localparam logic signed [PROMPT_W-1:0] PROMPT_MIN = -24'sh800000;

   typedef enum logic [1:0] {
      STAGE_PULL_IN,
      STAGE_HISTOGRAM,
      STAGE_BOUNDARY_WAIT,
      STAGE_INTEGRATE
   } sync_stage_type;

   // how the values of one navigation bit are shaped
   typedef enum logic [2:0] {
      SHAPE_NOISY,
      SHAPE_CLEAN,
      SHAPE_ZERO,
      SHAPE_FULL_POS,
      SHAPE_FULL_NEG,
      SHAPE_WEAK
   } bit_shape_type;

   // -------------------------------------------------------------------------
   // Bit decision predictor and response checker
   // -------------------------------------------------------------------------
   class bit_sync_scoreboard;
      logic [PULL_W-1:0]      pull_in_ms;
      logic [WIN_W-1:0]       window_ms;
      logic [PULL_W-1:0]      pull_cnt;
      sync_stage_type         stage;
      logic [WIN_W-1:0]       win_cnt;
      int unsigned            phase;
      int unsigned            hist [BIT_MS];
      sign_type               last_sign;
      int unsigned            boundary;
      int unsigned            ms_in_bit;
      longint                 energy;
      logic [SAMPLE_W-1:0]    bit_start;
      rsp_item_type           expected_bits_q [$];
      int                     mismatches;
      int                     responses;

      function new();
         pull_in_ms = PULL_IN_RESET;
         window_ms  = SYNC_WINDOW_RESET;
         pull_cnt   = '0;
         stage      = STAGE_PULL_IN;
         win_cnt    = '0;
         phase      = 0;
         foreach (hist[j]) hist[j] = 0;
         last_sign  = SGN_ZERO;
         boundary   = 0;
         ms_in_bit  = 0;
         energy     = 0;
         bit_start  = '0;
         mismatches = 0;
         responses  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_PULL_IN)
            pull_in_ms = data[PULL_W-1:0];
         else
            window_ms = data[WIN_W-1:0];
      endfunction

      function void step_phase();
         phase = (phase + 1 >= BIT_MS) ? 0 : phase + 1;
      endfunction

      function void note_request(logic signed [PROMPT_W-1:0] value,
                                 logic [SAMPLE_W-1:0] sample);
         sign_type     sgn;
         int unsigned  best;
         rsp_item_type bit_out;
         if (stage == STAGE_PULL_IN) begin
            if (pull_cnt != 8'd255) pull_cnt++;
            if (pull_cnt < pull_in_ms) return;
            stage = STAGE_HISTOGRAM;
         end
         if (stage == STAGE_HISTOGRAM) begin
            sgn = (value > 0) ? SGN_POS : ((value < 0) ? SGN_NEG : SGN_ZERO);
            if ((sgn == SGN_POS && last_sign == SGN_NEG) ||
                (sgn == SGN_NEG && last_sign == SGN_POS)) begin
               if (hist[phase] < 2047) hist[phase]++;
            end
            last_sign = sgn;
            step_phase();
            if (win_cnt != 11'd2047) win_cnt++;
            if (win_cnt >= window_ms) begin
               best = 0;
               for (int j = 1; j < BIT_MS; j++)
                  if (hist[j] > hist[best]) best = j;
               boundary = best;
               stage = STAGE_BOUNDARY_WAIT;
            end
            return;
         end
         if (stage == STAGE_BOUNDARY_WAIT) begin
            if (phase == boundary) begin
               stage     = STAGE_INTEGRATE;
               ms_in_bit = 1;
               energy    = value;
               bit_start = sample;
            end
            step_phase();
            return;
         end
         if (ms_in_bit == 0) bit_start = sample;
         energy += value;
         ms_in_bit++;
         step_phase();
         if (ms_in_bit < BIT_MS) return;
         bit_out.nav_bit          = (energy >= 0);
         bit_out.bit_start_sample = bit_start;
         bit_out.boundary_phase   = boundary[PHASE_OUT_W-1:0];
         expected_bits_q.push_back(bit_out);
         energy    = 0;
         ms_in_bit = 0;
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         rsp_item_type want;
         responses++;
         if (expected_bits_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d: unexpected, tdata %h", responses, data);
            return;
         end
         want = expected_bits_q.pop_front();
         // tdata: [0] nav_bit, [64:1] bit_start_sample, [69:65] boundary_phase
         if (data[0] !== want.nav_bit || data[64:1] !== want.bit_start_sample ||
             data[69:65] !== want.boundary_phase || data[71:70] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d: want %0b %h %0d, got %0b %h %0d pad %b",
                        responses, want.nav_bit, want.bit_start_sample, want.boundary_phase,
                        data[0], data[64:1], data[69:65], data[71:70]);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT, signals
   // -------------------------------------------------------------------------
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   bit_sync_scoreboard sb = new();

   // stimulus bookkeeping
   int                    burst_left   = 0;
   logic [SAMPLE_W-1:0]   sample_cursor = '0;
   int unsigned           flip_a, flip_b;   // reversal phases in the histogram
   bit                    run_negative = 1'b0;
   bit_shape_type         shape        = SHAPE_NOISY;
   int                    bits_started = 0;

   // receiver hold-off requests, raised by the stimulus, served below
   int                    holds_asked  = 0;
   int                    holds_done;
   int                    hold_left;
   logic [15:0]           rx_cycle;
   int                    idle_cycles;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   nav_bit_sync_integrator_top #(
      .MS_PER_BIT (BIT_MS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------

   // One request; bursts of random length with random gaps between them.
   // The request is handed to the predictor at the edge that accepts it.
   task automatic send_request(input logic signed [PROMPT_W-1:0] value,
                               input logic [SAMPLE_W-1:0] sample);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tdata  <= {sample, value};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(value, sample);
      burst_left--;
   endtask

   // Stop offering, wait for every pending bit, then let a boundary scan finish
   // in case the last request closed the window.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.expected_bits_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(idx, data);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Sample index mostly steps forward, now and then jumps anywhere in 64 bits.
   task automatic next_sample(output logic [SAMPLE_W-1:0] sample);
      sample = sample_cursor;
      if ($urandom_range(0, 31) == 0)
         sample_cursor = {$urandom, $urandom};
      else
         sample_cursor = sample_cursor + $urandom_range(1, 20000);
   endtask

   // Prompt value shaped by where the block is: during the histogram the sign
   // reverses at two fixed phases (equal counts, so the lower one should win),
   // afterwards each bit starts at the boundary with its own shape and sign.
   task automatic pick_prompt(output logic signed [PROMPT_W-1:0] value);
      logic signed [PROMPT_W-1:0] mag;
      int unsigned                ph;
      bit                         zero_safe;
      mag = PROMPT_W'($urandom_range(1, 24'h7FFFFF));
      ph  = sb.phase;
      if (sb.stage == STAGE_PULL_IN || sb.stage == STAGE_HISTOGRAM) begin
         if (ph == flip_a || ph == flip_b) run_negative = !run_negative;
         // a zero next to a reversal phase would hide that reversal
         zero_safe = ph != flip_a && ph != flip_b &&
                     (ph + 1) % BIT_MS != flip_a && (ph + 1) % BIT_MS != flip_b;
         if (zero_safe && $urandom_range(0, 9) == 0)
            value = '0;
         else
            value = run_negative ? -mag : mag;
         return;
      end
      if (ph == sb.boundary) begin
         case (bits_started)
            0:       shape = SHAPE_ZERO;
            1:       shape = SHAPE_FULL_POS;
            2:       shape = SHAPE_FULL_NEG;
            3:       shape = SHAPE_WEAK;
            default: shape = bit_shape_type'($urandom_range(0, 5));
         endcase
         run_negative = 1'($urandom_range(0, 1));
         bits_started++;
      end
      case (shape)
         SHAPE_CLEAN:    value = run_negative ? -mag : mag;
         SHAPE_ZERO:     value = '0;
         SHAPE_FULL_POS: value = PROMPT_MAX;
         SHAPE_FULL_NEG: value = PROMPT_MIN;
         SHAPE_WEAK:     value = PROMPT_W'($signed($urandom_range(0, 8)) - 4);  // sum near zero
         default: begin
            case ($urandom_range(0, 9))
               0:       value = '0;
               1, 2:    value = run_negative ? mag : -mag;
               default: value = run_negative ? -mag : mag;
            endcase
         end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Receiver: own stall pattern, plus a long hold-off on request
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_cycle   <= '0;
         hold_left  <= 0;
         holds_done <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1'b1;
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (holds_done != holds_asked) begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_cycle[9:8])
               2'd0:    rsp_tready <= 1'b1;                      // no stalls
               2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
               2'd2:    rsp_tready <= (rx_cycle[1:0] == 2'd0);   // one in four
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // watchdog: too long without any handshake means the block hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic signed [PROMPT_W-1:0] value;
      logic [SAMPLE_W-1:0]        sample;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pull-in at its longest; upper CSR bits must be dropped (0x7FF -> 255)
      write_csr(CSR_SYNC_WINDOW, 11'd20);
      write_csr(CSR_PULL_IN, 11'h7FF);

      // field extremes while the block is still discarding requests
      send_request(PROMPT_MAX, '0);
      send_request(PROMPT_MIN, '1);
      send_request('0, 64'h5555_5555_5555_5555);
      send_request(24'sd1, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(-24'sd1, 64'h8000_0000_0000_0001);
      send_request(24'sh555555, 64'h7FFF_FFFF_FFFF_FFFE);
      quiesce();

      // lowering the count, still above the item count, keeps discarding
      write_csr(CSR_PULL_IN, 11'd200);
      send_request(24'shAAAAAA, 64'h0123_4567_89AB_CDEF);
      send_request(PROMPT_MAX, 64'hFEDC_BA98_7654_3210);
      quiesce();

      // widest window, and a pull-in of zero: the next request starts sync
      write_csr(CSR_SYNC_WINDOW, 11'd2047);
      write_csr(CSR_PULL_IN, 11'd0);

      // histogram with two equal reversal phases
      flip_a = $urandom_range(1, BIT_MS - 1);
      do flip_b = $urandom_range(1, BIT_MS - 1); while (flip_b == flip_a);
      sample_cursor = {$urandom, $urandom};
      for (int k = 0; k <= HIST_ITEMS; k++) begin
         // a zero window closes on the very next histogram request
         if (k == HIST_ITEMS) begin
            quiesce();
            write_csr(CSR_SYNC_WINDOW, 11'd0);
         end
         pick_prompt(value);
         next_sample(sample);
         send_request(value, sample);
      end

      // integration: random bits, a long receiver hold-off and CSR changes
      // between phases (they must no longer change anything)
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300)
            holds_asked <= holds_asked + 1;
         if (n == 550) begin
            quiesce();
            write_csr(CSR_PULL_IN, 11'd1);
            write_csr(CSR_SYNC_WINDOW, 11'd20);
         end
         if (n == 1000) begin
            quiesce();
            write_csr(CSR_PULL_IN, 11'd255);
            write_csr(CSR_SYNC_WINDOW, 11'd1500);
         end
         if (n == 1400) begin
            quiesce();
            write_csr(CSR_PULL_IN, CSR_DATA_W'($urandom_range(0, 2047)));
            write_csr(CSR_SYNC_WINDOW, CSR_DATA_W'($urandom_range(0, 2047)));
         end
         pick_prompt(value);
         next_sample(sample);
         send_request(value, sample);
      end

      // drain, then a tail to catch stray responses
      quiesce();

      if (sb.mismatches == 0 && sb.expected_bits_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### nav_bit_sync_integrator_top.f
hdl/nbs_pkg.sv
hdl/nbs_hist_mem.sv
hdl/nbs_ctrl.sv
hdl/nav_bit_sync_integrator_top.sv
verif/testbench.sv
